### hdl/hsc_pkg.sv
`default_nettype none

package hsc_pkg;

  localparam int DEPTH = 1024;
  localparam int AW    = $clog2(DEPTH);  // store index
  localparam int CW    = AW + 1;         // count, holds DEPTH itself
  localparam int XW    = AW + 2;         // child index, up to 2*DEPTH

  localparam int VAL_W   = 32;
  localparam int TALLY_W = 32;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  typedef enum logic [1:0] {
    KIND_DONE = 2'd0,
    KIND_ELEM = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // saturating add of a small increment
  function automatic logic [TALLY_W-1:0] sat_add(input logic [TALLY_W-1:0] t,
                                                 input logic [1:0] inc);
    logic [TALLY_W:0] sum;
    sum = {1'b0, t} + (TALLY_W+1)'(inc);
    return sum[TALLY_W] ? {TALLY_W{1'b1}} : sum[TALLY_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/heap_sort_step_count.sv
`default_nettype none
// Load and fetch items: one per cycle while idle and the output does not stall; a result
// passes a pending register, then an output register. A final load holds the input
// while the heap sort runs out of the element memory: a sift level reads the left child,
// reads the right child, then compares and writes; a build node first reads its value; an
// extraction reads the root and the end and writes the root to the end; then done is posted.
// Reset clears the counters, the sorted flag and handshake state; the element memory is not cleared.
module heap_sort_step_count (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_tvalid,
  output logic                        in_tready,
  input  wire  [hsc_pkg::VAL_W-1:0]   in_tdata,   // [31:0] value
  input  wire  [0:0]                  in_tuser,   // [0] req_type
  input  wire                         in_tlast,   // is_final_load
  output logic                        out_tvalid,
  input  wire                         out_tready,
  output logic [63:0]                 out_tdata,  // [31:0] sorted_value, [63:32] step_total
  output logic [1:0]                  out_tuser,  // [1:0] result_kind
  output logic                        out_tlast   // last_of_set
);
  import hsc_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_BLD_RD  = 11'b00000000010,
    S_BLD_VAL = 11'b00000000100,
    S_SIFT_CHK= 11'b00000001000,
    S_SIFT_L  = 11'b00000010000,
    S_SIFT_CMP= 11'b00000100000,
    S_NEXT    = 11'b00001000000,
    S_EXT_RD0 = 11'b00010000000,
    S_EXT_RDI = 11'b00100000000,
    S_EXT_WR  = 11'b01000000000,
    S_FIN     = 11'b10000000000
  } state_t;

  logic [VAL_W-1:0] store_mem [DEPTH];
  logic [VAL_W-1:0] rd_r;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_wa, mem_ra;
  logic [VAL_W-1:0] mem_wd;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      rp_r, rp_nxt;
  logic               sorted_r, sorted_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;
  logic               ovf_r, ovf_nxt;
  logic               ext_r, ext_nxt;
  logic [AW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      size_r, size_nxt;
  logic [AW-1:0]      hole_r, hole_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [VAL_W-1:0]   root_r, root_nxt;
  logic [VAL_W-1:0]   left_val_r, left_val_nxt;

  logic               p_valid_r, p_valid_nxt;
  kind_t              p_kind_r, p_kind_nxt;
  logic               p_last_r, p_last_nxt;
  logic               p_mem_r, p_mem_nxt;
  logic [TALLY_W-1:0] p_tally_r, p_tally_nxt;

  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [VAL_W-1:0]   out_value_r;
  logic               out_last_r;
  logic [TALLY_W-1:0] out_tally_r;

  logic               in_acc, p_move, p_free, ovf;
  logic [CW-1:0]      cnt_eff, n_load;
  logic [XW-1:0]      left_idx, right_idx, size_x;
  logic               left_ok, use_left, move;
  logic [VAL_W-1:0]   tgt_val;
  logic [AW-1:0]      tgt_idx;

  assign p_move    = p_valid_r && (!out_valid_r || out_tready);
  assign p_free    = !p_valid_r || p_move;
  assign in_tready = (state_r == S_IDLE) && p_free;
  assign in_acc    = in_tvalid && in_tready;

  assign cnt_eff = sorted_r ? '0 : cnt_r;
  assign ovf     = cnt_eff == CW'(DEPTH);
  assign n_load  = ovf ? cnt_eff : cnt_eff + CW'(1);

  assign left_idx  = {1'b0, hole_r, 1'b1};
  assign right_idx = left_idx + XW'(1);
  assign size_x    = {1'b0, size_r};
  assign left_ok   = left_idx < size_x;
  assign use_left  = (right_idx >= size_x) || ($signed(left_val_r) > $signed(rd_r));
  assign tgt_val   = use_left ? left_val_r : rd_r;
  assign tgt_idx   = use_left ? left_idx[AW-1:0] : right_idx[AW-1:0];
  assign move      = $signed(tgt_val) > $signed(val_r);

  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_r <= store_mem[mem_ra];
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    rp_nxt       = rp_r;
    sorted_nxt   = sorted_r;
    tally_nxt    = tally_r;
    ovf_nxt      = ovf_r;
    ext_nxt      = ext_r;
    i_nxt        = i_r;
    size_nxt     = size_r;
    hole_nxt     = hole_r;
    val_nxt      = val_r;
    root_nxt     = root_r;
    left_val_nxt = left_val_r;
    p_valid_nxt  = p_valid_r;
    p_kind_nxt   = p_kind_r;
    p_last_nxt   = p_last_r;
    p_mem_nxt    = p_mem_r;
    p_tally_nxt  = p_tally_r;
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = '0;
    mem_re       = 1'b0;
    mem_ra       = '0;
    if (p_move) p_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == REQ_LOAD) begin
            // a load after a sort opens a fresh set
            if (sorted_r) begin
              rp_nxt     = '0;
              sorted_nxt = 1'b0;
              tally_nxt  = '0;
            end
            if (!ovf) begin
              mem_we = 1'b1;
              mem_wa = cnt_eff[AW-1:0];
              mem_wd = in_tdata;
            end
            cnt_nxt = n_load;
            if (in_tlast) begin
              ovf_nxt   = ovf;
              ext_nxt   = 1'b0;
              tally_nxt = '0;
              i_nxt     = AW'((n_load - CW'(1)) >> 1);
              state_nxt = S_BLD_RD;
            end else if (ovf) begin
              p_valid_nxt = 1'b1;
              p_kind_nxt  = KIND_ERR;
              p_last_nxt  = 1'b0;
              p_mem_nxt   = 1'b0;
              p_tally_nxt = '0;
            end
          end else begin
            p_valid_nxt = 1'b1;
            p_kind_nxt  = KIND_ERR;
            p_last_nxt  = 1'b0;
            p_mem_nxt   = 1'b0;
            p_tally_nxt = '0;
            if (sorted_r && (rp_r < cnt_r)) begin
              mem_re     = 1'b1;
              mem_ra     = rp_r[AW-1:0];
              p_kind_nxt = KIND_ELEM;
              p_mem_nxt  = 1'b1;
              p_last_nxt = (rp_r + CW'(1)) == cnt_r;
              rp_nxt     = rp_r + CW'(1);
            end
          end
        end
      end
      S_BLD_RD: begin
        mem_re    = 1'b1;
        mem_ra    = i_r;
        state_nxt = S_BLD_VAL;
      end
      S_BLD_VAL: begin
        val_nxt   = rd_r;
        hole_nxt  = i_r;
        size_nxt  = cnt_r;
        state_nxt = S_SIFT_CHK;
      end
      S_SIFT_CHK: begin
        if (left_ok) begin
          mem_re    = 1'b1;
          mem_ra    = left_idx[AW-1:0];
          state_nxt = S_SIFT_L;
        end else begin
          // no child: drop the held value into the hole
          mem_we    = 1'b1;
          mem_wa    = hole_r;
          mem_wd    = val_r;
          state_nxt = S_NEXT;
        end
      end
      S_SIFT_L: begin
        left_val_nxt = rd_r;
        mem_re       = 1'b1;
        mem_ra       = right_idx[AW-1:0];
        state_nxt    = S_SIFT_CMP;
      end
      S_SIFT_CMP: begin
        mem_we = 1'b1;
        mem_wa = hole_r;
        if (move) begin
          mem_wd    = tgt_val;
          hole_nxt  = tgt_idx;
          tally_nxt = sat_add(tally_r, 2'd2);
          state_nxt = S_SIFT_CHK;
        end else begin
          mem_wd    = val_r;
          tally_nxt = sat_add(tally_r, 2'd1);
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (i_r == '0) begin
          if (ext_r) begin
            state_nxt = S_FIN;
          end else begin
            ext_nxt   = 1'b1;
            i_nxt     = AW'(cnt_r - CW'(1));
            state_nxt = S_EXT_RD0;
          end
        end else begin
          i_nxt     = i_r - AW'(1);
          state_nxt = ext_r ? S_EXT_RD0 : S_BLD_RD;
        end
      end
      S_EXT_RD0: begin
        mem_re    = 1'b1;
        mem_ra    = '0;
        state_nxt = S_EXT_RDI;
      end
      S_EXT_RDI: begin
        root_nxt  = rd_r;
        mem_re    = 1'b1;
        mem_ra    = i_r;
        state_nxt = S_EXT_WR;
      end
      S_EXT_WR: begin
        // root goes to the end; the old end value sifts down from the root
        mem_we    = 1'b1;
        mem_wa    = i_r;
        mem_wd    = root_r;
        val_nxt   = rd_r;
        hole_nxt  = '0;
        size_nxt  = {1'b0, i_r};
        tally_nxt = sat_add(tally_r, 2'd1);
        state_nxt = S_SIFT_CHK;
      end
      S_FIN: begin
        if (p_free) begin
          p_valid_nxt = 1'b1;
          p_kind_nxt  = ovf_r ? KIND_ERR : KIND_DONE;
          p_tally_nxt = ovf_r ? '0 : tally_r;
          p_last_nxt  = 1'b0;
          p_mem_nxt   = 1'b0;
          sorted_nxt  = 1'b1;
          rp_nxt      = '0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rp_r        <= '0;
      sorted_r    <= 1'b0;
      tally_r     <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rp_r      <= rp_nxt;
      sorted_r  <= sorted_nxt;
      tally_r   <= tally_nxt;
      p_valid_r <= p_valid_nxt;
      if (p_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ovf_r      <= ovf_nxt;
    ext_r      <= ext_nxt;
    i_r        <= i_nxt;
    size_r     <= size_nxt;
    hole_r     <= hole_nxt;
    val_r      <= val_nxt;
    root_r     <= root_nxt;
    left_val_r <= left_val_nxt;
    p_kind_r   <= p_kind_nxt;
    p_last_r   <= p_last_nxt;
    p_mem_r    <= p_mem_nxt;
    p_tally_r  <= p_tally_nxt;
    if (p_move) begin
      out_kind_r  <= p_kind_r;
      out_value_r <= p_mem_r ? rd_r : '0;
      out_last_r  <= p_last_r;
      out_tally_r <= p_tally_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_tally_r, out_value_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("element count beyond store depth");

  a_rp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sorted_r |-> rp_r <= cnt_r)
    else $error("read pointer past element count");

  a_left_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SIFT_L) |-> left_idx < size_x)
    else $error("sift read outside heap");

  a_fin_posts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && p_free) |=> (sorted_r && p_valid_r && state_r == S_IDLE))
    else $error("sort end did not post its result");

  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (p_valid_r && !p_move) |=> p_valid_r)
    else $error("pending result lost");

endmodule

`default_nettype wire
